// ===== hdl/rlc_pkg.sv =====
// Shared types and constants of the RPC reply LRU cache.
`timescale 1ns / 1ps
`default_nettype none

package rlc_pkg;

    localparam int CACHE_ENTRIES_DEF = 64;

    localparam int HOST_W = 32;
    localparam int PORT_W = 16;
    localparam int XID_W  = 32;
    localparam int LEN_W  = 14;
    localparam int SLOT_W = 6;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH,
        ST_SEARCH_END,
        ST_LK_DECIDE,
        ST_AGE,
        ST_AGE_END,
        ST_COMMIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic search_step;
        logic age_step;
        logic clr_addr;
        logic set_lk_limit;
        logic commit;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_insert;
        logic active;
        logic count_zero;
        logic addr_last;
        logic found;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/rlc_req_if.sv =====
// Request channel carrying one lookup or insert item.
`timescale 1ns / 1ps
`default_nettype none

interface rlc_req_if
    import rlc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [HOST_W-1:0] client_host;
    logic [PORT_W-1:0] client_port;
    logic [XID_W-1:0]  transaction_id;
    logic [LEN_W-1:0]  reply_length;

    modport source (
        output valid, action, client_host, client_port, transaction_id, reply_length,
        input  ready
    );

    modport sink (
        input  valid, action, client_host, client_port, transaction_id, reply_length,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/rlc_rsp_if.sv =====
// Response channel carrying one result item.
`timescale 1ns / 1ps
`default_nettype none

interface rlc_rsp_if
    import rlc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  stored_length;
    logic              inserted;
    logic              evicted;

    modport source (
        output valid, hit, slot, stored_length, inserted, evicted,
        input  ready
    );

    modport sink (
        input  valid, hit, slot, stored_length, inserted, evicted,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/rpc_reply_lru_cache_top.sv =====
// Top level of the RPC reply LRU cache: controller and datapath.
// Usage:
//   i_req carries one item per handshake: action 0 looks a key up, action 1
//   inserts a key with its reply length. o_rsp returns exactly one result
//   item per request item. i_cfg_we/i_cfg_wdata write cache_disabled; the
//   user must write it while the block is idle, which the block itself does
//   not enforce. With it set, inserts return all zeros and change nothing.
//   A lookup makes a search pass over the held entries and, on a hit, then
//   a recency pass; an insert makes one recency pass, or none when the table
//   is empty or the cache is disabled, and a lookup of an empty table none.
//   Each pass visits one entry per cycle through the registered read port
//   of the entry memories; one item is in work at a time, and the next
//   request item is taken once the result is registered.
//   The result sits in an output register, so the next request item is
//   taken while an earlier result still waits for o_rsp.ready; a stalled
//   receiver holds the controller only when a second result is finished.
//   Reset clears the entry count and cache_disabled; entry memories are not
//   cleared, since only slots below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module rpc_reply_lru_cache_top
    import rlc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rlc_req_if.sink    i_req,
    rlc_rsp_if.source  o_rsp,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    rlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rlc_dpath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_action         (i_req.action),
        .i_client_host    (i_req.client_host),
        .i_client_port    (i_req.client_port),
        .i_transaction_id (i_req.transaction_id),
        .i_reply_length   (i_req.reply_length),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_hit            (o_rsp.hit),
        .o_slot           (o_rsp.slot),
        .o_stored_length  (o_rsp.stored_length),
        .o_inserted       (o_rsp.inserted),
        .o_evicted        (o_rsp.evicted)
    );

    assign i_req.ready = w_in_ready;

endmodule

`default_nettype wire

// ===== hdl/rlc_ctrl.sv =====
// Sequencing state machine of the RPC reply LRU cache.
`timescale 1ns / 1ps
`default_nettype none

module rlc_ctrl
    import rlc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!i_sts.is_insert) begin
                    n_state = i_sts.count_zero ? ST_FINISH : ST_SEARCH;
                end else if (!i_sts.active) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = i_sts.count_zero ? ST_COMMIT : ST_AGE;
                end
            end
            ST_SEARCH: begin
                if (i_sts.addr_last) begin
                    n_state = ST_SEARCH_END;
                end
            end
            ST_SEARCH_END: begin
                n_state = ST_LK_DECIDE;
            end
            ST_LK_DECIDE: begin
                n_state = i_sts.found ? ST_AGE : ST_FINISH;
            end
            ST_AGE: begin
                if (i_sts.addr_last) begin
                    n_state = ST_AGE_END;
                end
            end
            ST_AGE_END: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // take no item while reset is held
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
            end
            ST_LK_DECIDE: begin
                o_cmd.clr_addr     = 1'b1;
                o_cmd.set_lk_limit = 1'b1;
            end
            ST_AGE: begin
                o_cmd.age_step = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/rlc_dpath.sv =====
// Entry memories, scan pointer, best-match tracking and result register.
`timescale 1ns / 1ps
`default_nettype none

module rlc_dpath
    import rlc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_action,
    input  wire logic [HOST_W-1:0] i_client_host,
    input  wire logic [PORT_W-1:0] i_client_port,
    input  wire logic [XID_W-1:0]  i_transaction_id,
    input  wire logic [LEN_W-1:0]  i_reply_length,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_hit,
    output logic [SLOT_W-1:0]      o_slot,
    output logic [LEN_W-1:0]       o_stored_length,
    output logic                   o_inserted,
    output logic                   o_evicted
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] RANK_OLDEST = IDX_W'(CACHE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] COUNT_FULL  = CNT_W'(CACHE_ENTRIES);

    logic [HOST_W-1:0] mem_host [CACHE_ENTRIES];
    logic [PORT_W-1:0] mem_port [CACHE_ENTRIES];
    logic [XID_W-1:0]  mem_xid  [CACHE_ENTRIES];
    logic [LEN_W-1:0]  mem_len  [CACHE_ENTRIES];
    logic [IDX_W-1:0]  mem_rank [CACHE_ENTRIES];

    logic              r_disabled;
    logic [CNT_W-1:0]  r_count;
    logic              r_is_ins;
    logic              r_active;
    logic              r_full;
    logic [HOST_W-1:0] r_host;
    logic [PORT_W-1:0] r_port;
    logic [XID_W-1:0]  r_xid;
    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_addr;
    logic [IDX_W-1:0]  r_rd_addr;
    logic              r_rd_srch;
    logic              r_rd_age;
    logic [HOST_W-1:0] r_host_q;
    logic [PORT_W-1:0] r_port_q;
    logic [XID_W-1:0]  r_xid_q;
    logic [IDX_W-1:0]  r_rank_q;
    logic [LEN_W-1:0]  r_len_q;
    logic              r_found;
    logic [IDX_W-1:0]  r_best;
    logic [IDX_W-1:0]  r_best_rank;
    logic [IDX_W-1:0]  r_limit;
    logic              r_out_valid;
    logic              r_out_hit;
    logic [SLOT_W-1:0] r_out_slot;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_ins;
    logic              r_out_evi;

    logic                    w_match;
    logic                    w_srch_upd;
    logic                    w_age_we;
    logic                    w_victim;
    logic                    w_commit_rank;
    logic                    w_rank_we;
    logic [IDX_W-1:0]        w_rank_wa;
    logic [IDX_W-1:0]        w_rank_wd;
    logic                    w_hit;
    logic [IDX_W+SLOT_W-1:0] w_best_ext;

    assign w_match = (r_host_q == r_host) && (r_port_q == r_port) && (r_xid_q == r_xid);
    assign w_srch_upd = r_rd_srch && w_match && (!r_found || (r_rank_q < r_best_rank));
    // every occupied entry more recent than the limit moves one place back
    assign w_age_we = r_rd_age && (r_rank_q < r_limit);
    // only an insert into a full table picks a victim
    assign w_victim = r_rd_age && r_active && r_full && (r_rank_q == RANK_OLDEST);
    assign w_commit_rank = i_cmd.commit && (r_active || (!r_is_ins && r_found));

    always_comb begin
        w_rank_we = w_age_we || w_commit_rank;
        w_rank_wa = w_commit_rank ? r_best : r_rd_addr;
        w_rank_wd = w_commit_rank ? '0 : r_rank_q + 1'b1;
    end

    assign w_hit      = !r_is_ins && r_found;
    assign w_best_ext = {{SLOT_W{1'b0}}, r_best};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disabled  <= 1'b0;
            r_count     <= '0;
            r_rd_srch   <= 1'b0;
            r_rd_age    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_disabled <= i_cfg_wdata;
            end
            r_rd_srch <= i_cmd.search_step;
            r_rd_age  <= i_cmd.age_step;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (w_srch_upd) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit && r_active && !r_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_ins <= (i_action == ACT_INSERT);
            r_active <= (i_action == ACT_INSERT) && !r_disabled;
            r_full   <= (r_count == COUNT_FULL);
            r_host   <= i_client_host;
            r_port   <= i_client_port;
            r_xid    <= i_transaction_id;
            r_len    <= i_reply_length;
            // a non-full insert lands in the first free slot
            r_best   <= r_count[IDX_W-1:0];
            r_limit  <= (r_count == COUNT_FULL) ? RANK_OLDEST : r_count[IDX_W-1:0];
        end else begin
            if (w_srch_upd || w_victim) begin
                r_best <= r_rd_addr;
            end
            if (i_cmd.set_lk_limit) begin
                r_limit <= r_best_rank;
            end
        end
        if (w_srch_upd) begin
            r_best_rank <= r_rank_q;
        end
        if (i_cmd.load || i_cmd.clr_addr) begin
            r_addr <= '0;
        end else if (i_cmd.search_step || i_cmd.age_step) begin
            r_addr <= r_addr + 1'b1;
        end
        r_rd_addr <= r_addr;
        if (i_cmd.emit) begin
            r_out_hit  <= w_hit;
            r_out_slot <= (w_hit || r_active) ? w_best_ext[SLOT_W-1:0] : '0;
            r_out_len  <= w_hit ? r_len_q : '0;
            r_out_ins  <= r_active;
            r_out_evi  <= r_active && r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_host_q <= mem_host[r_addr];
        r_port_q <= mem_port[r_addr];
        r_xid_q  <= mem_xid[r_addr];
        r_rank_q <= mem_rank[r_addr];
        r_len_q  <= mem_len[r_best];
        if (w_rank_we) begin
            mem_rank[w_rank_wa] <= w_rank_wd;
        end
        if (i_cmd.commit && r_active) begin
            mem_host[r_best] <= r_host;
            mem_port[r_best] <= r_port;
            mem_xid[r_best]  <= r_xid;
            mem_len[r_best]  <= r_len;
        end
    end

    always_comb begin
        o_sts.is_insert  = r_is_ins;
        o_sts.active     = r_active;
        o_sts.count_zero = (r_count == '0);
        o_sts.addr_last  = (CNT_W'(r_addr) == (r_count - CNT_W'(1)));
        o_sts.found      = r_found;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_slot          = r_out_slot;
    assign o_stored_length = r_out_len;
    assign o_inserted      = r_out_ins;
    assign o_evicted       = r_out_evi;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("entry count beyond table size");

    a_rank_port_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !w_age_we)
        else $error("ageing write collides with commit write");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_active && !r_full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("fill count did not advance on insert");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_ins))
        else $error("result reports both hit and insert");

endmodule

`default_nettype wire
